// ===== design/point_quantize_morton_key_core_assert.svh =====
// Assertion macros for the point quantizer and Morton key core.
`ifndef POINT_QUANTIZE_MORTON_KEY_CORE_ASSERT_SVH
`define POINT_QUANTIZE_MORTON_KEY_CORE_ASSERT_SVH

// Holds at every edge outside reset.
`define PQMK_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition at one edge forces the check at the next, reset included.
`define PQMK_ASSERT_NEXT(label, clk, cond, expr, msg) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) else $error(msg);

`endif

// ===== design/pqmk_pkg.sv =====
// Shared types, constants and helpers for the point quantizer core.
`default_nettype none

package pqmk_pkg;

  localparam int COORD_W  = 32;
  localparam int QUANT_W  = 16;
  localparam int KEY_W    = 48;
  localparam int NUM_AXES = 3;
  localparam int CFG_IDX_W = 3;
  // Dividend 2*diff*65535 + size stays below 2^50.
  localparam int REM_W    = 50;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUANT_W / DIV_BITS_PER_STAGE;
  localparam logic [QUANT_W-1:0] QUANT_MAX = {QUANT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MAX_X = 3'd1,
    CFG_BOX_MIN_Y = 3'd2,
    CFG_BOX_MAX_Y = 3'd3,
    CFG_BOX_MIN_Z = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } point_t;

  typedef struct packed {
    logic [QUANT_W-1:0] quant_x;
    logic [QUANT_W-1:0] quant_y;
    logic [QUANT_W-1:0] quant_z;
    logic [KEY_W-1:0]   morton_key;
  } result_t;

  // Control carried alongside the divider data.
  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } div_ctl_t;

  typedef struct packed {
    logic             qbit;
    logic [REM_W-1:0] rem;
  } div_step_t;

  // One restoring division step against a pre-shifted divisor.
  function automatic div_step_t div_step(input logic [REM_W-1:0] r,
                                         input logic [REM_W-1:0] dsh);
    div_step_t o;
    if (r >= dsh) begin
      o.qbit = 1'b1;
      o.rem  = r - dsh;
    end else begin
      o.qbit = 1'b0;
      o.rem  = r;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== design/pqmk_axis.sv =====
// One axis: offset, dividend build, pipelined long division, clamp.
`default_nettype none

module pqmk_axis (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire logic signed [pqmk_pkg::COORD_W-1:0]     coord,
  input  wire logic signed [pqmk_pkg::COORD_W-1:0]     box_lo,
  input  wire logic signed [pqmk_pkg::COORD_W-1:0]     box_hi,
  output logic                                         out_valid,
  output logic [pqmk_pkg::QUANT_W-1:0]                 quant
);

  localparam int CW  = pqmk_pkg::COORD_W;
  localparam int RW  = pqmk_pkg::REM_W;
  localparam int QW  = pqmk_pkg::QUANT_W;
  localparam int NS  = pqmk_pkg::DIV_STAGES;
  localparam int BPS = pqmk_pkg::DIV_BITS_PER_STAGE;

  // stage A: offsets
  logic                a_valid;
  logic signed [CW:0]  a_diff;
  logic signed [CW:0]  a_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_diff <= {coord[CW-1], coord} - {box_lo[CW-1], box_lo};
    a_size <= {box_hi[CW-1], box_hi} - {box_lo[CW-1], box_lo};
  end

  // divider pipeline, index 0 is the dividend stage
  pqmk_pkg::div_ctl_t ctl [0:NS];
  logic [RW-1:0]      rem [0:NS];
  logic [CW-1:0]      den [0:NS];
  logic [QW-1:0]      quo [0:NS];

  logic [RW-1:0] diff_ext;
  logic [RW-1:0] size_ext;
  assign diff_ext = {{(RW-CW){1'b0}}, a_diff[CW-1:0]};
  assign size_ext = {{(RW-CW){1'b0}}, a_size[CW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= a_valid;
    end
    ctl[0].zero <= (a_size <= 0) || (a_diff <= 0);
    ctl[0].sat  <= (a_diff >= a_size);
    // 2*diff*65535 + size
    rem[0] <= (diff_ext << (QW + 1)) - (diff_ext << 1) + size_ext;
    den[0] <= a_size[CW-1:0];
    quo[0] <= '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int B_HI = QW - 1 - BPS * s;
    logic [RW-1:0]         dbase;
    pqmk_pkg::div_step_t   st0;
    pqmk_pkg::div_step_t   st1;
    logic [QW-1:0]         quo_next;

    assign dbase = {{(RW-CW-1){1'b0}}, den[s], 1'b0};

    always_comb begin
      st0 = pqmk_pkg::div_step(rem[s], dbase << B_HI);
      st1 = pqmk_pkg::div_step(st0.rem, dbase << (B_HI - 1));
      quo_next = quo[s];
      quo_next[B_HI]     = st0.qbit;
      quo_next[B_HI - 1] = st1.qbit;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].valid <= 1'b0;
      end else begin
        ctl[s+1].valid <= ctl[s].valid;
      end
      ctl[s+1].zero <= ctl[s].zero;
      ctl[s+1].sat  <= ctl[s].sat;
      rem[s+1] <= st1.rem;
      den[s+1] <= den[s];
      quo[s+1] <= quo_next;
    end
  end

  // clamp and register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl[NS].valid;
    end
    if (ctl[NS].zero) begin
      quant <= '0;
    end else if (ctl[NS].sat) begin
      quant <= pqmk_pkg::QUANT_MAX;
    end else begin
      quant <= quo[NS];
    end
  end

endmodule

`default_nettype wire

// ===== design/point_quantize_morton_key_core.sv =====
// Top level: point quantizer and 3D Morton key generator.
`default_nettype none
// Usage:
//  - Config channel: cfg_valid/cfg_ready with cfg_index (0..5 = min_x, max_x,
//    min_y, max_y, min_z, max_z) and cfg_data, signed Q16.16. cfg_ready is
//    always high; indexes above 5 are dropped. Write only while no point is
//    in flight.
//  - Input: a word (point) is taken at an edge with start high and busy low.
//    busy is high only during reset, so one point per cycle is sustained.
//  - Output: done pulses for one cycle with result valid; the receiver must
//    take it then, it cannot stall the core.
//  - Pipeline: from the accepting edge a point passes the input register,
//    offset stage, dividend stage, eight divider stages of two quotient
//    bits each, clamp register and key register, which raises done.
//  - Throughput: one point per cycle; the divider is fully pipelined per axis.
//  - Reset (rst, synchronous) clears all valid bits and the box to zero, so
//    every axis quantizes to 0 until the box is written.
//  - AXIS_BITS low bits of each axis enter the key; above 16 it acts as 16.

module point_quantize_morton_key_core #(
  parameter int AXIS_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire pqmk_pkg::point_t                       point,
  output logic                                        done,
  output pqmk_pkg::result_t                           result,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pqmk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [pqmk_pkg::COORD_W-1:0]           cfg_data
);

  localparam int CW = pqmk_pkg::COORD_W;
  localparam int QW = pqmk_pkg::QUANT_W;
  localparam int NA = pqmk_pkg::NUM_AXES;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // box registers
  logic signed [CW-1:0] box_lo [0:NA-1];
  logic signed [CW-1:0] box_hi [0:NA-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NA; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pqmk_pkg::CFG_BOX_MIN_X: box_lo[0] <= cfg_data;
        pqmk_pkg::CFG_BOX_MAX_X: box_hi[0] <= cfg_data;
        pqmk_pkg::CFG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        pqmk_pkg::CFG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        pqmk_pkg::CFG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        pqmk_pkg::CFG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid;
  pqmk_pkg::point_t in_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_pt <= point;
  end

  logic signed [CW-1:0] coord [0:NA-1];
  logic                 ax_valid [0:NA-1];
  logic [QW-1:0]        ax_quant [0:NA-1];

  assign coord[0] = in_pt.coord_x;
  assign coord[1] = in_pt.coord_y;
  assign coord[2] = in_pt.coord_z;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    pqmk_axis u_axis (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (in_valid),
      .coord     (coord[a]),
      .box_lo    (box_lo[a]),
      .box_hi    (box_hi[a]),
      .out_valid (ax_valid[a]),
      .quant     (ax_quant[a])
    );
  end

  // bit interleave: axis a, bit i lands at key bit 3i+a
  logic [pqmk_pkg::KEY_W-1:0] key;

  for (genvar i = 0; i < QW; i++) begin : g_key
    for (genvar a = 0; a < NA; a++) begin : g_lane
      if (i < AXIS_BITS) begin : g_on
        assign key[NA*i + a] = ax_quant[a][i];
      end else begin : g_off
        assign key[NA*i + a] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ax_valid[0];
    end
    result.quant_x    <= ax_quant[0];
    result.quant_y    <= ax_quant[1];
    result.quant_z    <= ax_quant[2];
    result.morton_key <= key;
  end

`include "point_quantize_morton_key_core_assert.svh"

  `PQMK_ASSERT_NEXT(a_rst_no_done, clk, rst, !done, "result strobe after reset")
  `PQMK_ASSERT_ALWAYS(a_key_x0, clk, rst, !done || (result.morton_key[0] == result.quant_x[0]), "key bit 0 != x bit 0")
  `PQMK_ASSERT_ALWAYS(a_key_y0, clk, rst, !done || (result.morton_key[1] == result.quant_y[0]), "key bit 1 != y bit 0")
  `PQMK_ASSERT_ALWAYS(a_key_z0, clk, rst, !done || (result.morton_key[2] == result.quant_z[0]), "key bit 2 != z bit 0")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the point quantizer and Morton key core.
`timescale 1ns / 100ps

class quant_scoreboard;
  pqmk_pkg::result_t pending_results[$];
  int mismatches;
  int words_checked;
  logic signed [31:0] box_lo[3];
  logic signed [31:0] box_hi[3];

  function new();
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = '0;
      box_hi[a] = '0;
    end
    mismatches = 0;
    words_checked = 0;
  endfunction

  function void set_box(int idx, logic [31:0] value);
    if (idx % 2 == 0) box_lo[idx / 2] = value;
    else box_hi[idx / 2] = value;
  endfunction

  // Exact rational quantize with half-up rounding and clamp.
  function logic [15:0] quantize(logic signed [31:0] v, logic signed [31:0] lo,
                                 logic signed [31:0] hi);
    longint size;
    longint diff;
    longint unsigned num;
    longint unsigned q;
    size = longint'(hi) - longint'(lo);
    diff = longint'(v) - longint'(lo);
    if (size <= 0 || diff <= 0) return 16'd0;
    num = longint'(diff) * 65535;
    q = (2 * num + size) / (2 * size);
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  function logic [47:0] interleave(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
    logic [47:0] k;
    k = '0;
    for (int i = 0; i < 16; i++) begin
      k[3*i]   = qx[i];
      k[3*i+1] = qy[i];
      k[3*i+2] = qz[i];
    end
    return k;
  endfunction

  function void note_point(pqmk_pkg::point_t p);
    pqmk_pkg::result_t r;
    r.quant_x = quantize(p.coord_x, box_lo[0], box_hi[0]);
    r.quant_y = quantize(p.coord_y, box_lo[1], box_hi[1]);
    r.quant_z = quantize(p.coord_z, box_lo[2], box_hi[2]);
    r.morton_key = interleave(r.quant_x, r.quant_y, r.quant_z);
    pending_results.push_back(r);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on word %0d: %s got %h want %h", words_checked, what, got, want);
    mismatches++;
  endtask

  task check_result(pqmk_pkg::result_t got);
    pqmk_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report("unexpected word", got.morton_key, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.quant_x !== want.quant_x) report("quant_x", got.quant_x, want.quant_x);
    if (got.quant_y !== want.quant_y) report("quant_y", got.quant_y, want.quant_y);
    if (got.quant_z !== want.quant_z) report("quant_z", got.quant_z, want.quant_z);
    if (got.morton_key !== want.morton_key)
      report("morton_key", got.morton_key, want.morton_key);
    words_checked++;
  endtask
endclass

module tb_top;

  localparam int LATENCY = 13;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pqmk_pkg::point_t point = '0;
  logic done;
  pqmk_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pqmk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pqmk_pkg::COORD_W-1:0] cfg_data = '0;

  quant_scoreboard sb = new();
  int idle_cycles = 0;
  int points_sent = 0;
  bit quiet_tail = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  point_quantize_morton_key_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results cannot be held off: sample every done cycle at the edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Watchdog: cycles with nothing accepted on either side.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Box register write; only called while the pipeline is drained.
  // Leaves cfg_valid high so writes can run back to back.
  task write_box(pqmk_pkg::cfg_idx_e idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_box(int'(idx), value);
  endtask

  task set_box_axes(logic [31:0] lo[3], logic [31:0] hi[3]);
    write_box(pqmk_pkg::CFG_BOX_MIN_X, lo[0]);
    write_box(pqmk_pkg::CFG_BOX_MAX_X, hi[0]);
    write_box(pqmk_pkg::CFG_BOX_MIN_Y, lo[1]);
    write_box(pqmk_pkg::CFG_BOX_MAX_Y, hi[1]);
    write_box(pqmk_pkg::CFG_BOX_MIN_Z, lo[2]);
    write_box(pqmk_pkg::CFG_BOX_MAX_Z, hi[2]);
    cfg_valid <= 1'b0;
  endtask

  // Offer a point, sometimes after a random gap; holds start across items.
  task send_point(pqmk_pkg::point_t p);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_point(p);
    points_sent++;
  endtask

  task drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Point near or inside the current box, sometimes anywhere.
  function logic [31:0] rand_coord(int axis);
    longint lo;
    longint hi;
    longint v;
    lo = longint'(sb.box_lo[axis]);
    hi = longint'(sb.box_hi[axis]);
    if ($urandom_range(0, 3) == 0 || hi <= lo) return rand_word();
    case ($urandom_range(0, 4))
      0: v = lo + $urandom_range(0, 2) - 1;
      1: v = hi + $urandom_range(0, 2) - 1;
      default: v = lo + ((hi - lo) * longint'($urandom_range(0, 1 << 20)) >>> 20);
    endcase
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  initial begin
    logic [31:0] lo[3];
    logic [31:0] hi[3];
    pqmk_pkg::point_t p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset box: every axis is empty, all quantize to zero.
    send_point('{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000});

    // Directed: full signed range box, extremes, half-way point.
    for (int a = 0; a < 3; a++) begin
      lo[a] = 32'h8000_0000;
      hi[a] = 32'h7fff_ffff;
    end
    drain();
    set_box_axes(lo, hi);
    send_point('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
    send_point('{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff});
    send_point('{32'h8000_0001, 32'h7fff_fffe, 32'h5555_5555});

    // Size 2: exact half at diff 1 (65535/2), inverted and empty axes.
    lo[0] = 32'h0000_0000; hi[0] = 32'h0000_0002;
    lo[1] = 32'h0000_0005; hi[1] = 32'h0000_0005;
    lo[2] = 32'h0001_0000; hi[2] = 32'hffff_0000;
    drain();
    set_box_axes(lo, hi);
    send_point('{32'h0000_0001, 32'h0000_0006, 32'h0000_0000});
    send_point('{32'h0000_0002, 32'h0000_0004, 32'h7fff_ffff});
    send_point('{32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    send_point('{32'h0000_0003, 32'h0000_0005, 32'h0001_0000});

    // Unit box [0,1] in Q16.16 with points below, inside and above.
    for (int a = 0; a < 3; a++) begin
      lo[a] = 32'h0000_0000;
      hi[a] = 32'h0001_0000;
    end
    drain();
    set_box_axes(lo, hi);
    send_point('{32'h0000_8000, 32'h0000_0001, 32'h0000_ffff});
    send_point('{32'hffff_ffff, 32'h0001_0001, 32'h0001_0000});
    send_point('{32'h0000_aaaa, 32'h0000_5555, 32'h0000_0000});

    // Random phases: new box every ~70 points, with some empty/inverted axes.
    for (int ph = 0; ph < 20; ph++) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = rand_word();
        hi[a] = rand_word();
        if ($urandom_range(0, 4) != 0 && $signed(hi[a]) < $signed(lo[a])) begin
          logic [31:0] t;
          t = lo[a]; lo[a] = hi[a]; hi[a] = t;
        end
        if ($urandom_range(0, 5) == 0) hi[a] = lo[a] + $urandom_range(1, 70000);
      end
      drain();
      set_box_axes(lo, hi);
      if (ph >= 17) quiet_tail = 1'b1;
      for (int n = 0; n < 70; n++) begin
        p.coord_x = rand_coord(0);
        p.coord_y = rand_coord(1);
        p.coord_z = rand_coord(2);
        send_point(p);
      end
    end

    drain();
    $display("Covered %0d points over 24 box settings, incl. empty, inverted and full boxes.",
             points_sent);
    $display("Checked %0d result words, %0d mismatches.", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
